FILE: hdl/buvs_pkg.sv
// shared types, constants and step table for the battery undervoltage step-down
package buvs_pkg;

  // register indexes on the configuration port
  localparam logic [7:0] REG_LOW_THRESHOLD   = 8'd0;
  localparam logic [7:0] REG_LOW_COUNT_LIMIT = 8'd1;

  // reset values of the configuration registers
  localparam logic [7:0] LOW_THRESHOLD_RST   = 8'd175;
  localparam logic [3:0] LOW_COUNT_LIMIT_RST = 4'd2;

  // drive levels below this select phase-correct pwm
  localparam logic [7:0] SLOW_PWM_BELOW = 8'd15;
  localparam logic [3:0] LOW_COUNT_MAX  = 4'd15;
  localparam logic [7:0] REDUCTION_MAX  = 8'd255;

  // one result item
  typedef struct packed {
    logic [7:0] drive_level;
    logic       slow_pwm_mode;
    logic       stepdown_blink;
    logic       shut_down;
  } result_t;

  // step-down size as a function of the present real output
  function automatic logic [3:0] step_for(input logic [7:0] real_level);
    logic [3:0] step;
    if (real_level > 8'd200) begin
      step = 4'd10;
    end else if (real_level > 8'd150) begin
      step = 4'd7;
    end else if (real_level > 8'd100) begin
      step = 4'd5;
    end else if (real_level > 8'd50) begin
      step = 4'd3;
    end else begin
      step = 4'd1;
    end
    return step;
  endfunction

endpackage

FILE: hdl/battery_undervoltage_stepdown.sv
// top level: low-battery step-down of a pwm light, one control pass per transfer
//
// Each input transfer is one pass of the control loop; it yields exactly one result
// transfer. The block takes one pass every cycle: the result is computed in one
// combinational step from the pass and the held state (low count, reduction, shutdown
// latch) and lands in an output register, backed by a one-entry skid register, so
// in_stall rises only when both are full. Configuration (low_threshold at index 0,
// low_count_limit at index 1) is always ready; unknown indexes are ignored. Write it
// only while the block is idle.
module battery_undervoltage_stepdown (
  input  logic       clk,
  input  logic       rst,
  // configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] requested_level,
  input  logic       sample_ready,
  input  logic [7:0] battery_sample,
  input  logic       ramping_active,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] drive_level,
  output logic       slow_pwm_mode,
  output logic       stepdown_blink,
  output logic       shut_down
);

  // configuration registers
  logic [7:0] low_threshold;
  logic [3:0] low_count_limit;

  // loop state
  logic [3:0] low_count;
  logic [3:0] low_count_next;
  logic [7:0] reduction;
  logic [7:0] reduction_next;
  logic       off_latched;
  logic       off_latched_next;

  // output and skid registers
  buvs_pkg::result_t out_data;
  buvs_pkg::result_t skid_data;
  logic              skid_valid;
  buvs_pkg::result_t result;

  // intermediate values of one pass
  logic       in_xfer;
  logic       out_xfer;
  logic [7:0] drive_raw;
  logic       low_sample;
  logic [3:0] count_bumped;
  logic       do_step;
  logic [8:0] step_sum;
  logic [7:0] reduction_stepped;
  logic       latch_now;
  logic [7:0] drive_final;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      low_threshold   <= buvs_pkg::LOW_THRESHOLD_RST;
      low_count_limit <= buvs_pkg::LOW_COUNT_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        buvs_pkg::REG_LOW_THRESHOLD:   low_threshold   <= cfg_data;
        buvs_pkg::REG_LOW_COUNT_LIMIT: low_count_limit <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // one control pass
  always_comb begin
    drive_raw  = (requested_level > reduction) ? (requested_level - reduction) : 8'd0;
    low_sample = (battery_sample < low_threshold) && !ramping_active;
    if (!low_sample) begin
      count_bumped = 4'd0;
    end else if (low_count == buvs_pkg::LOW_COUNT_MAX) begin
      count_bumped = buvs_pkg::LOW_COUNT_MAX;
    end else begin
      count_bumped = low_count + 4'd1;
    end
    do_step  = sample_ready && (count_bumped >= low_count_limit);
    step_sum = {1'b0, reduction} + {5'd0, buvs_pkg::step_for(drive_raw)};
    reduction_stepped = step_sum[8] ? buvs_pkg::REDUCTION_MAX : step_sum[7:0];
    latch_now   = do_step && (reduction_stepped > requested_level);
    drive_final = latch_now ? 8'd0 : drive_raw;

    // state updates, frozen once shut down
    low_count_next   = low_count;
    reduction_next   = reduction;
    off_latched_next = off_latched;
    if (!off_latched && sample_ready) begin
      low_count_next = do_step ? 4'd0 : count_bumped;
      if (do_step) begin
        reduction_next   = reduction_stepped;
        off_latched_next = latch_now;
      end
    end

    if (off_latched) begin
      result.drive_level    = 8'd0;
      result.slow_pwm_mode  = 1'b1;
      result.stepdown_blink = 1'b0;
      result.shut_down      = 1'b1;
    end else begin
      result.drive_level    = drive_final;
      result.slow_pwm_mode  = drive_final < buvs_pkg::SLOW_PWM_BELOW;
      result.stepdown_blink = do_step;
      result.shut_down      = latch_now;
    end
  end

  // loop state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      low_count   <= 4'd0;
      reduction   <= 8'd0;
      off_latched <= 1'b0;
    end else if (in_xfer) begin
      low_count   <= low_count_next;
      reduction   <= reduction_next;
      off_latched <= off_latched_next;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || out_xfer) begin
        out_valid  <= skid_valid || in_xfer;
        skid_valid <= 1'b0;
      end else if (in_xfer) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_xfer) begin
      out_data <= skid_valid ? skid_data : result;
    end
    if (in_xfer && out_valid && !out_xfer) begin
      skid_data <= result;
    end
  end

  assign drive_level    = out_data.drive_level;
  assign slow_pwm_mode  = out_data.slow_pwm_mode;
  assign stepdown_blink = out_data.stepdown_blink;
  assign shut_down      = out_data.shut_down;

`ifndef SYNTHESIS
  // a filled skid stage always has a result waiting ahead of it
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid stage holds data while output register is empty");

  // shutdown latch never releases
  assert property (@(posedge clk) disable iff (rst) off_latched |=> off_latched)
    else $error("shutdown latch released");

  // state is frozen after shutdown
  assert property (@(posedge clk) disable iff (rst)
    off_latched |=> ($stable(reduction) && $stable(low_count)))
    else $error("loop state changed after shutdown");

  // a step-down pass always raises the reduction unless it is saturated
  assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !off_latched && sample_ready && do_step && reduction != 8'd255)
      |=> (reduction > $past(reduction)))
    else $error("step-down pass did not raise the reduction");
`endif

endmodule
